[hw/rtl/kts_pkg.sv]
// Shared types and constants for the keyframe track sampler.
package kts_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_CH,
    ST_ONE,
    ST_S0,
    ST_S1,
    ST_FR,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_res_t;

endpackage

[hw/rtl/kts_div.sv]
// Serial restoring divider for the Q0.16 interpolation weight.
module kts_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       num_i,
  input  logic [31:0]       den_i,
  output kts_pkg::div_res_t res_o
);
  import kts_pkg::*;

  logic [32:0] rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  logic [31:0] den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] rem2;

  // num is below den, so the quotient fits in FRAC_BITS bits
  always_comb begin
    rem2   = {rem_q[31:0], 1'b0};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d  = rem2 - {1'b0, den_q};
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        rem_d  = rem2;
        quot_d = {quot_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(FRAC_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) den_q <= den_i;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule

[hw/rtl/keyframe_track_sampler.sv]
// Top level of the keyframe track sampler: key store, search and interpolation.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  in      | input     | in_valid_i/in_ready_o | action, channel, key_slot, key data,
//          |           |                       | count_in_use, sample_time
//  out     | output    | out_valid_o/out_ready_i| found_index, found, fraction,
//          |           |                       | out_x/y/z, zero_span
//
// Loads and count writes are done from ST_IDLE, which stays ready. A sample
// searches the key intervals of its channel circularly, where the single read
// port of the key memory fetches one key per cycle. A wrap to key zero passes
// through ST_S0 again, and a failed search refetches keys zero and one. A
// single-key channel skips the search. The weight comes from a 16-step divider
// that holds the sample in ST_DIV. After reset a clearing pass sets every
// channel's count to one and its cache to zero; no request is taken during it.
// A finished result waits in the output register while the next request is
// taken; a sample stalls in its last state only while that register is full.
module keyframe_track_sampler #(
  parameter int CHANNELS = 64,
  parameter int KEYS     = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [5:0]         channel_i,
  input  logic [7:0]         key_slot_i,
  input  logic [31:0]        key_time_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  input  logic [8:0]         count_in_use_i,
  input  logic [31:0]        sample_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         found_index_o,
  output logic               found_o,
  output logic [16:0]        fraction_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               zero_span_o
);
  import kts_pkg::*;

  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KIW   = $clog2(KEYS);
  localparam int NW    = $clog2(KEYS + 1);
  localparam int DEPTH = CHANNELS * KEYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTW   = NW + KIW;

  // key word: {time, x, y, z}
  logic [127:0] kmem_q [DEPTH];
  logic [CTW-1:0] ctab_q [CHANNELS];

  state_e state_q, state_d;

  logic [127:0]   krd_q;
  logic [AW-1:0]  k_raddr;
  logic           k_we;
  logic [AW-1:0]  k_waddr;
  logic [CTW-1:0] ct_rd_q;
  logic [CIW-1:0] ct_raddr;
  logic           ct_we;
  logic [CIW-1:0] ct_waddr;
  logic [CTW-1:0] ct_wdata;

  logic [CIW-1:0] clr_q, ch_q;
  logic [AW-1:0]  base_q;
  logic [31:0]    t_q;
  logic [NW-1:0]  n_q;
  logic [KIW-1:0] start_q, r_q, k_q;
  logic           fail_q, found_q, zspan_q, oor_q;
  logic [127:0]   lo_q, hi_q;
  logic [16:0]    frac_q;
  logic [1:0]     comp_q;
  logic signed [50:0] prod_q;
  logic [31:0]    res_q [3];

  logic           accept;
  logic           ch_ok;
  logic [CIW-1:0] ch_idx;
  logic [AW-1:0]  in_base;
  logic [NW-1:0]  cnt_sat;
  logic [NW-1:0]  rd_n;
  logic [KIW-1:0] rd_cache, start_sel, r_next;
  logic           hit;
  logic [32:0]    num_s, den_s, num_abs, den_abs;
  logic           div_start;
  div_res_t       div_res;
  logic [31:0]    mix_a, mix_b;
  logic signed [32:0] mix_diff;
  logic signed [34:0] mix_q;
  logic           out_load;

  assign accept  = in_valid_i && in_ready_o;
  assign ch_ok   = 32'(channel_i) < CHANNELS;
  assign ch_idx  = CIW'(channel_i);
  assign in_base = AW'(ch_idx) * AW'(KEYS);
  assign in_ready_o = (state_q == ST_IDLE);

  // saturate the requested key count to 1..KEYS
  always_comb begin
    if (count_in_use_i == 9'd0) cnt_sat = NW'(1);
    else if (32'(count_in_use_i) > KEYS) cnt_sat = NW'(KEYS);
    else cnt_sat = NW'(count_in_use_i);
  end

  assign rd_n     = ct_rd_q[CTW-1:KIW];
  assign rd_cache = ct_rd_q[KIW-1:0];
  assign start_sel = (NW'(rd_cache) >= rd_n - NW'(1)) ? '0 : rd_cache;
  assign r_next   = (NW'(r_q) + NW'(1) == n_q - NW'(1)) ? '0 : r_q + KIW'(1);
  assign hit      = (t_q > lo_q[127:96]) && (t_q < krd_q[127:96]);

  // signed span and offset of the chosen interval
  assign num_s   = {1'b0, t_q} - {1'b0, lo_q[127:96]};
  assign den_s   = {1'b0, hi_q[127:96]} - {1'b0, lo_q[127:96]};
  assign num_abs = num_s[32] ? -num_s : num_s;
  assign den_abs = den_s[32] ? -den_s : den_s;

  always_comb begin
    case (comp_q)
      2'd0: begin
        mix_a = lo_q[95:64];
        mix_b = hi_q[95:64];
      end
      2'd1: begin
        mix_a = lo_q[63:32];
        mix_b = hi_q[63:32];
      end
      default: begin
        mix_a = lo_q[31:0];
        mix_b = hi_q[31:0];
      end
    endcase
  end
  assign mix_diff = $signed({mix_b[31], mix_b}) - $signed({mix_a[31], mix_a});
  assign mix_q    = prod_q[50:16];

  kts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_abs[31:0]),
    .den_i   (den_abs[31:0]),
    .res_o   (div_res)
  );

  assign out_load = (state_q == ST_DONE) && (!out_valid_o || out_ready_i);

  // next state and memory ports
  always_comb begin
    state_d   = state_q;
    k_raddr   = base_q;
    k_we      = 1'b0;
    k_waddr   = in_base + AW'(key_slot_i);
    ct_raddr  = ch_idx;
    ct_we     = 1'b0;
    ct_waddr  = ch_q;
    ct_wdata  = {n_q, k_q};
    div_start = 1'b0;
    case (state_q)
      ST_CLR: begin
        ct_we    = 1'b1;
        ct_waddr = clr_q;
        ct_wdata = {NW'(1), KIW'(0)};
        if (32'(clr_q) == CHANNELS - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_LOAD: k_we = ch_ok && (32'(key_slot_i) < KEYS);
            ACT_COUNT: begin
              ct_we    = ch_ok;
              ct_waddr = ch_idx;
              ct_wdata = {cnt_sat, KIW'(0)};
            end
            ACT_SAMPLE: state_d = ST_CH;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CH: begin
        if (oor_q) state_d = ST_DONE;
        else if (rd_n == NW'(1)) state_d = ST_ONE;
        else begin
          k_raddr = base_q + AW'(start_sel);
          state_d = ST_S0;
        end
      end
      ST_ONE: state_d = ST_MUL;
      ST_S0: begin
        k_raddr = base_q + AW'(r_q) + AW'(1);
        state_d = ST_S1;
      end
      ST_S1: begin
        if (fail_q || hit) state_d = ST_FR;
        else if (r_next == start_q || r_next == '0) state_d = ST_S0;
        else k_raddr = base_q + AW'(r_next) + AW'(1);
      end
      ST_FR: begin
        if (den_s != '0 && num_s[32] == den_s[32] && num_s != '0 &&
            num_abs < den_abs) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else state_d = ST_MUL;
      end
      ST_DIV: if (div_res.done) state_d = ST_MUL;
      ST_MUL: state_d = ST_ADD;
      ST_ADD: if (comp_q == 2'd2) state_d = ST_DONE;
              else state_d = ST_MUL;
      ST_DONE: begin
        if (out_load) begin
          ct_we   = !oor_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) clr_q <= clr_q + CIW'(1);
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (k_we) kmem_q[k_waddr] <= {key_time_i, value_x_i, value_y_i, value_z_i};
    krd_q <= kmem_q[k_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ct_we) ctab_q[ct_waddr] <= ct_wdata;
    ct_rd_q <= ctab_q[ct_raddr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ch_q    <= ch_idx;
        base_q  <= in_base;
        t_q     <= sample_time_i;
        oor_q   <= !ch_ok;
        fail_q  <= 1'b0;
        found_q <= 1'b0;
        zspan_q <= 1'b0;
        k_q     <= '0;
        frac_q  <= '0;
        comp_q  <= '0;
        res_q[0] <= '0;
        res_q[1] <= '0;
        res_q[2] <= '0;
      end
      ST_CH: begin
        n_q     <= rd_n;
        start_q <= start_sel;
        r_q     <= start_sel;
      end
      ST_ONE: begin
        lo_q <= krd_q;
        hi_q <= krd_q;
      end
      ST_S0: lo_q <= krd_q;
      ST_S1: begin
        hi_q <= krd_q;
        if (fail_q) k_q <= '0;
        else if (hit) begin
          k_q     <= r_q;
          found_q <= 1'b1;
        end else if (r_next == start_q) begin
          fail_q <= 1'b1;
          r_q    <= '0;
        end else if (r_next == '0) r_q <= '0;
        else begin
          lo_q <= krd_q;
          r_q  <= r_next;
        end
      end
      ST_FR: begin
        // equal times, opposite signs or a zero offset give zero; a full span clamps to one
        if (den_s == '0) zspan_q <= 1'b1;
        else if (num_s[32] == den_s[32] && num_s != '0 && num_abs >= den_abs)
          frac_q <= FRAC_ONE;
      end
      ST_DIV: if (div_res.done) frac_q <= {1'b0, div_res.quot};
      ST_MUL: prod_q <= mix_diff * $signed({1'b0, frac_q}) + 51'sd32768;
      ST_ADD: begin
        res_q[comp_q] <= mix_a + mix_q[31:0];
        comp_q <= comp_q + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_index_o <= 8'(k_q);
      found_o       <= found_q;
      fraction_o    <= frac_q;
      out_x_o       <= res_q[0];
      out_y_o       <= res_q[1];
      out_z_o       <= res_q[2];
      zero_span_o   <= zspan_q;
    end
  end

endmodule

[hw/rtl/kts_checker.sv]
// Port-level checks for the keyframe track sampler, bound to the top level.
module kts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  found_index_o,
  input logic        found_o,
  input logic [16:0] fraction_o,
  input logic        zero_span_o
);
  import kts_pkg::*;

  // hold the result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fraction_o))
    else $error("result dropped or changed while stalled");

  // drop readiness once a sample is in work
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_SAMPLE |=> !in_ready_o)
    else $error("request taken during a sample");

  // loads and count writes cause no result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i != ACT_SAMPLE |=> !$rose(out_valid_o))
    else $error("result without a sample");

  // a zero span carries a zero weight, a result that is not found reports key zero
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!zero_span_o || fraction_o == 17'd0) &&
                    (found_o || found_index_o == 8'd0))
    else $error("inconsistent result fields");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (.*);
